### rtl/core/mror_pkg.sv
// Shared types, command and status codes, and defaults for the multi-reader overwrite ring.
package mror_pkg;

    // Default build sizes.
    localparam int DEPTH_DEF   = 16;
    localparam int READERS_DEF = 4;

    // Fixed field widths.
    localparam int CMD_W    = 3;
    localparam int STATUS_W = 2;
    localparam int WORD_W   = 64;
    localparam int LEN_W    = 8;
    localparam int CAP_W    = 5;
    localparam int ML_W     = 9;

    // Configuration port.
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    // Configuration register reset values.
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;
    localparam logic [ML_W-1:0]  ML_RESET  = 9'd256;

    // Command codes carried on the input tuser.
    typedef enum logic [CMD_W-1:0] {
        CMD_PUT    = 3'd0,
        CMD_ATTACH = 3'd1,
        CMD_DETACH = 3'd2,
        CMD_PEEK   = 3'd3,
        CMD_POP    = 3'd4
    } t_cmd;

    // Result status codes carried on the output tuser.
    typedef enum logic [STATUS_W-1:0] {
        ST_DONE     = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_INACTIVE = 2'd2
    } t_status;

    // Configuration register indexes (byte address bit 2).
    typedef enum logic {
        REG_CAPACITY = 1'b0,
        REG_MAX_LEN  = 1'b1
    } t_reg_idx;

    // Per-reader update strobes; at most one is set in a cycle.
    typedef struct packed {
        logic put;
        logic attach;
        logic detach;
        logic pop;
    } t_rd_ctl;

endpackage

### rtl/core/mror_reader.sv
// One reader of the ring: active flag, read index and fill count.
module mror_reader
    import mror_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  t_rd_ctl                          i_ctl,
    input  logic [$clog2(DEPTH+1)-1:0]       i_cap,
    input  logic [$clog2(DEPTH)-1:0]         i_oldest,
    input  logic [$clog2(DEPTH+1)-1:0]       i_total_fill,
    input  logic [$clog2(DEPTH)-1:0]         i_next_wr,
    output logic                             o_active,
    output logic [$clog2(DEPTH)-1:0]         o_index,
    output logic [$clog2(DEPTH+1)-1:0]       o_fill
);

    localparam int IDX_W  = $clog2(DEPTH);
    localparam int FILL_W = $clog2(DEPTH+1);

    logic              r_active;
    logic [IDX_W-1:0]  r_index;
    logic [FILL_W-1:0] r_fill;

    // Step an index forward, wrapping at the capacity in use.
    function automatic logic [IDX_W-1:0] f_adv(input logic [IDX_W-1:0] idx,
                                               input logic [FILL_W-1:0] cap);
        logic [IDX_W:0] nxt;
        nxt = (IDX_W+1)'(idx) + (IDX_W+1)'(1);
        if (nxt >= (IDX_W+1)'(cap)) begin
            return '0;
        end
        return nxt[IDX_W-1:0];
    endfunction

    // Reader state update. A put drags a full reader along to the new oldest slot.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_index  <= '0;
            r_fill   <= '0;
        end else if (i_ctl.attach) begin
            r_active <= 1'b1;
            r_index  <= i_oldest;
            r_fill   <= i_total_fill;
        end else if (i_ctl.detach) begin
            r_active <= 1'b0;
        end else if (i_ctl.pop) begin
            r_fill  <= r_fill - FILL_W'(1);
            r_index <= f_adv(r_index, i_cap);
        end else if (i_ctl.put && r_active) begin
            if (r_fill >= i_cap) begin
                r_index <= i_next_wr;
                r_fill  <= i_cap;
            end else begin
                r_fill  <= r_fill + FILL_W'(1);
            end
        end
    end

    assign o_active = r_active;
    assign o_index  = r_index;
    assign o_fill   = r_fill;

endmodule

### rtl/core/multi_reader_overwrite_ring.sv
// Top level of the multi-reader overwrite ring: command decode, slot stores and result register.
//
// A ring of message slots shared by several readers. Commands arrive on the slave stream:
// tuser carries the command (put, attach reader, detach reader, peek, pop) and tdata the
// reader number, a 64-bit message word and a requested length. Every command yields exactly
// one result on the master stream: tuser carries the status (done, reader empty, reader not
// active), tdata the peeked word, a length, the reader fill and a slot index.
// A put into a full ring overwrites the oldest slot; readers that were full move along.
// The APB port sets the capacity in use and the slot length in bytes; write it only while
// no command is in flight.
// The result of a command is registered and is valid after the edge that accepts the command.
// Throughput is one command per cycle; the slot stores are read and written once per cycle
// and all readers update in parallel. When the receiver stalls, the result register holds
// its transfer and the slave side takes no new command until the result is taken.
// Reset clears the write, oldest and fill counters, detaches every reader and restores the
// register defaults (capacity 16, length 256). The slot stores are not cleared.
module multi_reader_overwrite_ring
    import mror_pkg::*;
#(
    parameter int DEPTH   = DEPTH_DEF,
    parameter int READERS = READERS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Command stream.
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    // tdata from bit 0: reader_slot, msg_word, msg_length, zero fill
    input  logic [((((READERS > 1) ? $clog2(READERS) : 1) + WORD_W + LEN_W + 7) / 8) * 8 - 1:0]
                                  i_s_tdata,
    // tuser from bit 0: cmd
    input  logic [CMD_W-1:0]      i_s_tuser,
    // Result stream.
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // tdata from bit 0: data_out, length_out, remaining, slot_index, zero fill
    output logic [((WORD_W + LEN_W + $clog2(DEPTH+1) + $clog2(DEPTH) + 7) / 8) * 8 - 1:0]
                                  o_m_tdata,
    // tuser from bit 0: status
    output logic [STATUS_W-1:0]   o_m_tuser,
    // Configuration port.
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_AW-1:0]     paddr,
    input  logic [APB_DW-1:0]     pwdata,
    output logic [APB_DW-1:0]     prdata,
    output logic                  pready
);

    localparam int IDX_W  = $clog2(DEPTH);
    localparam int FILL_W = $clog2(DEPTH+1);
    localparam int RS_W   = (READERS > 1) ? $clog2(READERS) : 1;
    localparam int OUT_USED = WORD_W + LEN_W + FILL_W + IDX_W;
    localparam int OUT_W  = ((OUT_USED + 7) / 8) * 8;

    // Configuration registers.
    logic [CAP_W-1:0] r_capacity;
    logic [ML_W-1:0]  r_max_len;

    // Ring pointers.
    logic [IDX_W-1:0]  r_wr_idx;
    logic [IDX_W-1:0]  r_oldest;
    logic [FILL_W-1:0] r_total_fill;
    logic [IDX_W-1:0]  n_wr_idx;
    logic [IDX_W-1:0]  n_oldest;
    logic [FILL_W-1:0] n_total_fill;

    // Slot stores.
    logic [WORD_W-1:0] mem_word [DEPTH];
    logic [LEN_W-1:0]  mem_len  [DEPTH];
    logic [WORD_W-1:0] r_word_rd;
    logic [LEN_W-1:0]  r_len_rd;

    // Result register.
    logic              r_valid;
    t_status           r_status;
    logic [LEN_W-1:0]  r_len;
    logic [FILL_W-1:0] r_rem;
    logic [IDX_W-1:0]  r_slot;
    logic              r_peek;
    t_status           n_status;
    logic [LEN_W-1:0]  n_len;
    logic [FILL_W-1:0] n_rem;
    logic [IDX_W-1:0]  n_slot;
    logic              n_peek;

    // Command fields and decode.
    logic              accept;
    t_cmd              cmd;
    logic [RS_W-1:0]   rs;
    logic [WORD_W-1:0] msg_word;
    logic [LEN_W-1:0]  msg_length;
    logic              rs_valid;
    logic              rs_active;
    logic [IDX_W-1:0]  rs_index;
    logic [FILL_W-1:0] rs_fill;
    logic [FILL_W-1:0] cap;
    logic [ML_W-1:0]   max_len;
    logic [ML_W-1:0]   clip_len;
    logic              do_put;

    // Reader state.
    logic              w_active [READERS];
    logic [IDX_W-1:0]  w_index  [READERS];
    logic [FILL_W-1:0] w_fill   [READERS];
    t_rd_ctl           w_ctl    [READERS];

    // Step an index forward, wrapping at the capacity in use.
    function automatic logic [IDX_W-1:0] f_adv(input logic [IDX_W-1:0] idx,
                                               input logic [FILL_W-1:0] cap_in);
        logic [IDX_W:0] nxt;
        nxt = (IDX_W+1)'(idx) + (IDX_W+1)'(1);
        if (nxt >= (IDX_W+1)'(cap_in)) begin
            return '0;
        end
        return nxt[IDX_W-1:0];
    endfunction

    // Stream handshake: a new command enters whenever the result register frees up.
    assign o_s_tready = !r_valid || i_m_tready;
    assign accept     = i_s_tvalid && o_s_tready;

    // Unpack the command transfer.
    assign cmd        = t_cmd'(i_s_tuser);
    assign rs         = i_s_tdata[RS_W-1:0];
    assign msg_word   = i_s_tdata[RS_W +: WORD_W];
    assign msg_length = i_s_tdata[RS_W + WORD_W +: LEN_W];

    // Selected reader.
    assign rs_valid  = 32'(rs) < READERS;
    assign rs_active = rs_valid && w_active[rs];
    assign rs_index  = w_index[rs];
    assign rs_fill   = w_fill[rs];

    // Capacity in use, clamped to 1..DEPTH.
    always_comb begin
        if (r_capacity == '0) begin
            cap = FILL_W'(1);
        end else if (32'(r_capacity) > DEPTH) begin
            cap = FILL_W'(DEPTH);
        end else begin
            cap = FILL_W'(r_capacity);
        end
    end

    // Length clip: a zero slot length acts as one byte.
    assign max_len  = (r_max_len == '0) ? ML_W'(1) : r_max_len;
    assign clip_len = (ML_W'(msg_length) >= max_len) ? (max_len - ML_W'(1))
                                                     : ML_W'(msg_length);

    assign do_put = accept && (cmd == CMD_PUT);

    // Ring pointer update on a put; a full ring drops its oldest slot.
    always_comb begin
        n_wr_idx     = r_wr_idx;
        n_oldest     = r_oldest;
        n_total_fill = r_total_fill;
        if (do_put) begin
            n_wr_idx = f_adv(r_wr_idx, cap);
            if (r_total_fill >= cap) begin
                n_oldest     = f_adv(r_oldest, cap);
                n_total_fill = cap;
            end else begin
                n_total_fill = r_total_fill + FILL_W'(1);
            end
        end
    end

    // Result fields for the command.
    always_comb begin
        n_status = ST_DONE;
        n_len    = '0;
        n_rem    = '0;
        n_slot   = '0;
        n_peek   = 1'b0;
        case (cmd)
            CMD_PUT: begin
                n_len  = clip_len[LEN_W-1:0];
                n_slot = r_wr_idx;
            end
            CMD_ATTACH: begin
                if (!rs_valid) begin
                    n_status = ST_INACTIVE;
                end else begin
                    n_rem = r_total_fill;
                end
            end
            CMD_DETACH: begin
                if (!rs_active) begin
                    n_status = ST_INACTIVE;
                end
            end
            CMD_PEEK: begin
                if (!rs_active) begin
                    n_status = ST_INACTIVE;
                end else if (rs_fill == '0) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_peek = 1'b1;
                    n_rem  = rs_fill;
                    n_slot = rs_index;
                end
            end
            CMD_POP: begin
                if (!rs_active) begin
                    n_status = ST_INACTIVE;
                end else if (rs_fill == '0) begin
                    n_status = ST_EMPTY;
                end
            end
            default: begin
                n_status = ST_DONE;
            end
        endcase
    end

    // Readers.
    for (genvar g = 0; g < READERS; g++) begin : g_reader
        logic hit;
        assign hit = accept && (32'(rs) == g);
        assign w_ctl[g].put    = do_put;
        assign w_ctl[g].attach = hit && (cmd == CMD_ATTACH);
        assign w_ctl[g].detach = hit && (cmd == CMD_DETACH) && w_active[g];
        assign w_ctl[g].pop    = hit && (cmd == CMD_POP) && w_active[g] && (w_fill[g] != '0);

        mror_reader #(
            .DEPTH(DEPTH)
        ) u_reader (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_ctl[g]),
            .i_cap        (cap),
            .i_oldest     (r_oldest),
            .i_total_fill (r_total_fill),
            .i_next_wr    (n_wr_idx),
            .o_active     (w_active[g]),
            .o_index      (w_index[g]),
            .o_fill       (w_fill[g])
        );
    end

    // Slot stores: written by a put, read at the selected reader's index.
    always_ff @(posedge i_clk) begin
        if (do_put) begin
            mem_word[r_wr_idx] <= msg_word;
            mem_len[r_wr_idx]  <= clip_len[LEN_W-1:0];
        end
        if (accept) begin
            r_word_rd <= mem_word[rs_index];
            r_len_rd  <= mem_len[rs_index];
        end
    end

    // Ring pointers and result valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_idx     <= '0;
            r_oldest     <= '0;
            r_total_fill <= '0;
            r_valid      <= 1'b0;
        end else begin
            r_wr_idx     <= n_wr_idx;
            r_oldest     <= n_oldest;
            r_total_fill <= n_total_fill;
            if (accept) begin
                r_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Result payload, loaded on each accepted command.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status <= n_status;
            r_len    <= n_len;
            r_rem    <= n_rem;
            r_slot   <= n_slot;
            r_peek   <= n_peek;
        end
    end

    // Result transfer.
    assign o_m_tvalid = r_valid;
    assign o_m_tuser  = r_status;
    assign o_m_tdata  = {(OUT_W - OUT_USED)'(0), r_slot, r_rem,
                         (r_peek ? r_len_rd : r_len),
                         (r_peek ? r_word_rd : WORD_W'(0))};

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_RESET;
            r_max_len  <= ML_RESET;
        end else if (psel && penable && pwrite && pready) begin
            case (t_reg_idx'(paddr[2]))
                REG_CAPACITY: r_capacity <= pwdata[CAP_W-1:0];
                REG_MAX_LEN:  r_max_len  <= pwdata[ML_W-1:0];
                default:      r_capacity <= r_capacity;
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        case (t_reg_idx'(paddr[2]))
            REG_CAPACITY: prdata = APB_DW'(r_capacity);
            REG_MAX_LEN:  prdata = APB_DW'(r_max_len);
            default:      prdata = '0;
        endcase
    end

    assign pready = 1'b1;

endmodule
